// ===== design/lbpg_pkg.sv =====
// ----------------------------------------------------------------------------
// lbpg_pkg
// Shared sizes, register indexes, mode codes and controller interface types
// of the LED blink pattern generator.
// ----------------------------------------------------------------------------
package lbpg_pkg;

    localparam int PATTERN_DEPTH = 16;
    localparam int TIME_BITS     = 16;

    localparam int ADDR_W    = $clog2(PATTERN_DEPTH);
    localparam int POS_W     = $clog2(PATTERN_DEPTH + 1);
    localparam int ELAPSED_W = TIME_BITS + 1;
    localparam int REM_W     = TIME_BITS + 1;
    localparam int RND_W     = 16;
    localparam int DIV_CNT_W = $clog2(RND_W + 1);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int LEN_W     = 5;
    localparam int IDX_EXT_W = 9;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd3;

    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_ON      = 3'd1;
    localparam logic [2:0] MODE_PATTERN = 3'd2;
    localparam logic [2:0] MODE_BLINK   = 3'd3;
    localparam logic [2:0] MODE_ASYM    = 3'd4;
    localparam logic [2:0] MODE_RANDOM  = 3'd5;

    localparam logic REQ_TICK = 1'b0;

    typedef struct packed {
        logic capture;
        logic count;
        logic eval;
        logic div_step;
        logic div_finish;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_tick;
        logic need_div;
        logic div_done;
        logic out_free;
    } t_ctrl_status;

endpackage

// ===== design/lbpg_if.sv =====
// ----------------------------------------------------------------------------
// lbpg_if
// Request and result channels of the LED blink pattern generator.
// ----------------------------------------------------------------------------
interface lbpg_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [3:0]  entry_index;
    logic [15:0] entry_time;
    logic [15:0] rnd_sample;

    modport source (output valid, req_type, entry_index, entry_time, rnd_sample,
                    input ready);
    modport sink   (input valid, req_type, entry_index, entry_time, rnd_sample,
                    output ready);
endinterface

interface lbpg_res_if;
    logic valid;
    logic ready;
    logic led_level;
    logic toggled;

    modport source (output valid, led_level, toggled, input ready);
    modport sink   (input valid, led_level, toggled, output ready);
endinterface

// ===== design/lbpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbpg_ctrl
// Sequencer that steps one transaction through count, evaluate (ticks only), the
// optional serial remainder and result delivery.
// ----------------------------------------------------------------------------
module lbpg_ctrl
    import lbpg_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_COUNT = 5'b00010,
        S_EVAL  = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_COUNT;
                end
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                n_state     = i_status.is_tick ? S_EVAL : S_DONE;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_status.need_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.div_finish = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/lbpg_datapath.sv =====
// ----------------------------------------------------------------------------
// lbpg_datapath
// Configuration registers, pattern table, mode state, serial remainder unit
// and the result register.
// ----------------------------------------------------------------------------
module lbpg_datapath
    import lbpg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_req_type,
    input  logic [3:0]           i_entry_index,
    input  logic [15:0]          i_entry_time,
    input  logic [RND_W-1:0]     i_rnd_sample,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_led_level,
    output logic                 o_toggled,
    input  t_ctrl_cmd            i_cmd,
    output t_ctrl_status         o_status
);

    // Configuration.
    logic [2:0]           r_mode;
    logic [TIME_BITS-1:0] r_period_a;
    logic [TIME_BITS-1:0] r_period_b;
    logic [LEN_W-1:0]     r_pat_len;

    // Captured transaction.
    logic                 r_is_tick;
    logic [IDX_EXT_W-1:0] r_idx;
    logic [TIME_BITS-1:0] r_etime;
    logic [RND_W-1:0]     r_rnd;
    logic                 r_before;

    // Mode state.
    logic                 r_led;
    logic                 r_phase;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [POS_W-1:0]     r_pos;
    logic                 r_started;
    logic [TIME_BITS-1:0] r_rdelay;

    // Pattern table.
    logic [TIME_BITS-1:0] r_table [PATTERN_DEPTH];
    logic [TIME_BITS-1:0] r_rd_data;

    // Serial remainder.
    logic [REM_W-1:0]     r_div_rem;
    logic [TIME_BITS-1:0] r_div_d;
    logic [RND_W-1:0]     r_div_num;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // Result register.
    logic                 r_out_valid;
    logic                 r_out_led;
    logic                 r_out_tog;

    logic [31:0]          cfg_ext;
    logic [31:0]          etime_ext;
    logic                 tbl_we;
    logic [IDX_EXT_W-1:0] len_eff;
    logic [IDX_EXT_W-1:0] pos_ext;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic                 over_a;
    logic                 over_b;
    logic                 over_rd;
    logic                 b_gt_a;

    logic                 n_led;
    logic                 n_phase;
    logic [ELAPSED_W-1:0] n_elapsed;
    logic [POS_W-1:0]     n_pos;
    logic                 n_started;
    logic [TIME_BITS-1:0] n_rdelay;
    logic                 need_div;

    logic [REM_W-1:0]     rem_shift;
    logic [REM_W-1:0]     rem_sub;
    logic                 rem_ge;

    assign cfg_ext   = 32'(i_cfg_data);
    assign etime_ext = 32'(i_entry_time);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_OFF;
            r_period_a <= TIME_BITS'(500);
            r_period_b <= TIME_BITS'(500);
            r_pat_len  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:     r_mode     <= i_cfg_data[2:0];
                CFG_PERIOD_A: r_period_a <= cfg_ext[TIME_BITS-1:0];
                CFG_PERIOD_B: r_period_b <= cfg_ext[TIME_BITS-1:0];
                CFG_PAT_LEN:  r_pat_len  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_tick <= (i_req_type == REQ_TICK);
            r_idx     <= IDX_EXT_W'(i_entry_index);
            r_etime   <= etime_ext[TIME_BITS-1:0];
            r_rnd     <= i_rnd_sample;
            r_before  <= r_led;
        end
    end

    // Entries past the table depth are dropped.
    assign tbl_we = i_cmd.count && !r_is_tick && (r_idx < IDX_EXT_W'(PATTERN_DEPTH));

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[r_idx[ADDR_W-1:0]] <= r_etime;
        end
        r_rd_data <= r_table[r_pos[ADDR_W-1:0]];
    end

    assign elapsed_inc = (r_elapsed != ELAPSED_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign len_eff     = (IDX_EXT_W'(r_pat_len) > IDX_EXT_W'(PATTERN_DEPTH)) ?
                         IDX_EXT_W'(PATTERN_DEPTH) : IDX_EXT_W'(r_pat_len);
    assign pos_ext     = IDX_EXT_W'(r_pos);
    assign over_a      = r_elapsed > ELAPSED_W'(r_period_a);
    assign over_b      = r_elapsed > ELAPSED_W'(r_period_b);
    assign over_rd     = r_elapsed > ELAPSED_W'(r_rdelay);
    assign b_gt_a      = r_period_b > r_period_a;

    always_comb begin
        n_led     = r_led;
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_pos     = r_pos;
        n_started = r_started;
        n_rdelay  = r_rdelay;
        need_div  = 1'b0;
        case (r_mode)
            MODE_OFF: n_led = 1'b0;
            MODE_ON:  n_led = 1'b1;
            MODE_PATTERN: begin
                if (pos_ext < len_eff) begin
                    if (!r_started) begin
                        n_started = 1'b1;
                        n_elapsed = '0;
                        n_led     = 1'b1;
                    end else if (r_elapsed > ELAPSED_W'(r_rd_data)) begin
                        n_elapsed = '0;
                        n_led     = r_pos[0];
                        n_pos     = r_pos + 1'b1;
                    end
                end else begin
                    // Rewind tick: the LED keeps its level.
                    n_pos = '0;
                end
            end
            MODE_BLINK: begin
                if (over_a) begin
                    n_elapsed = '0;
                    n_phase   = !r_phase;
                    n_led     = !r_phase;
                end
            end
            MODE_ASYM: begin
                if (!r_phase) begin
                    if (over_a) begin
                        n_elapsed = '0;
                        n_led     = 1'b0;
                        n_phase   = 1'b1;
                    end
                end else if (over_b) begin
                    n_elapsed = '0;
                    n_led     = 1'b1;
                    n_phase   = 1'b0;
                end
            end
            MODE_RANDOM: begin
                if (over_rd) begin
                    n_elapsed = '0;
                    n_phase   = !r_phase;
                    n_led     = !r_phase;
                    // The drawn delay lands later when the remainder unit runs.
                    n_rdelay  = r_period_a;
                    need_div  = b_gt_a;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led     <= 1'b0;
            r_phase   <= 1'b0;
            r_elapsed <= '0;
            r_pos     <= '0;
            r_started <= 1'b0;
            r_rdelay  <= '0;
        end else if (i_cmd.count && r_is_tick) begin
            r_elapsed <= elapsed_inc;
        end else if (i_cmd.eval) begin
            r_led     <= n_led;
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_pos     <= n_pos;
            r_started <= n_started;
            r_rdelay  <= n_rdelay;
        end else if (i_cmd.div_finish) begin
            r_rdelay <= r_period_a + r_div_rem[TIME_BITS-1:0];
        end
    end

    // Restoring remainder, one bit of the random sample per cycle.
    assign rem_shift = {r_div_rem[REM_W-2:0], r_div_num[RND_W-1]};
    assign rem_ge    = rem_shift >= REM_W'(r_div_d);
    assign rem_sub   = rem_shift - REM_W'(r_div_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.eval && need_div) begin
            r_div_cnt <= DIV_CNT_W'(RND_W);
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && need_div) begin
            r_div_rem <= '0;
            r_div_d   <= r_period_b - r_period_a;
            r_div_num <= r_rnd;
        end else if (i_cmd.div_step) begin
            r_div_rem <= rem_ge ? rem_sub : rem_shift;
            r_div_num <= {r_div_num[RND_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_led <= r_led;
            r_out_tog <= r_led ^ r_before;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_level = r_out_led;
    assign o_toggled   = r_out_tog;

    assign o_status.is_tick  = r_is_tick;
    assign o_status.need_div = need_div;
    assign o_status.div_done = (r_div_cnt == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    ap_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(PATTERN_DEPTH))
        else $error("pattern position past table depth");

    ap_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_finish |-> (r_div_rem < REM_W'(r_div_d)))
        else $error("remainder not reduced below divisor");

    ap_write_keeps_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.count && !r_is_tick) |=> $stable(r_led))
        else $error("table write changed the LED level");

    ap_off_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && r_mode == MODE_OFF) |=> !r_led)
        else $error("LED lit after a tick in steady off mode");

endmodule

// ===== design/led_blink_pattern_generator_unit.sv =====
// A tick passes through the count, evaluate and done states after acceptance, a
// table write through count and done; a random-mode tick that draws a new delay
// also runs the bit-serial remainder. The single sequencer owning the state takes
// one transaction at a time and stalls in done while an earlier result is not taken.
// Reset: synchronous, active low; the pattern table is not cleared and holds
// unknown data until written.
// ----------------------------------------------------------------------------
// led_blink_pattern_generator_unit
// Top level of a single-LED pattern generator. Each request transaction is
// either a one-millisecond tick or a write into the pattern table, and each
// produces one result transaction with the LED level and a toggle flag.
// ----------------------------------------------------------------------------
module led_blink_pattern_generator_unit
    import lbpg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // The user must issue configuration writes only while the unit is idle; the unit does not enforce this.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    lbpg_req_if.sink             i_req,
    lbpg_res_if.source           o_res
);

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    // The sequencer accepts a request only when idle; the result register lets
    // the next request be accepted while an earlier result is still waiting.
    lbpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds every register the modes use, the pattern table with
    // its registered read port, and the remainder unit for random delays.
    lbpg_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req.req_type),
        .i_entry_index (i_req.entry_index),
        .i_entry_time  (i_req.entry_time),
        .i_rnd_sample  (i_req.rnd_sample),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_led_level   (o_res.led_level),
        .o_toggled     (o_res.toggled),
        .i_cmd         (cmd),
        .o_status      (status)
    );

endmodule
